@@ src/rmp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmp_pkg
// Shared constants and types for the modular matrix power unit.
// ----------------------------------------------------------------------------
package rmp_pkg;

  localparam int unsigned MOD_W   = 30;
  localparam int unsigned EXP_W   = 63;
  localparam int unsigned ORDER_W = 5;
  localparam int unsigned DEF_MAX_ORDER = 16;

  localparam logic [MOD_W-1:0] MODULUS = 30'd1000000007;

  // Barrett constant floor(2^60 / MODULUS), fits in 31 bits
  localparam logic [63:0] MU_FULL = 64'h1000_0000_0000_0000 / 64'd1000000007;
  localparam logic [30:0] MU      = MU_FULL[30:0];

  typedef struct packed {
    logic first;  // first term of a dot product
    logic last;   // last term, result goes to memory
  } mac_tag_t;

endpackage

@@ src/recurrence_matrix_power_mod_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recurrence_matrix_power_mod_unit
// Raises the companion matrix of f(t)=f(t-1)+f(t-order) to a power mod 1e9+7.
// ----------------------------------------------------------------------------
// Usage:
//  - Request in: exponent_i with in_valid_i; taken when in_stall_o is low.
//    in_stall_o stays high while a request is being worked on.
//  - Request out: value_o (entry [0][0] of the power) with out_valid_o,
//    held until out_stall_i is low. The next request may be taken while a
//    result still waits; its result is loaded only once the old one left.
//  - order_i / order_we_i write the recurrence order; write only when idle.
//    Order 0 acts as 1, orders above MAX_ORDER act as MAX_ORDER.
// Work, with d the order and b the exponent's bit length:
//   identity and companion matrix are written first, then one matrix
//   product of d*d*d terms, followed by a pipeline drain, for every set
//   bit and every square (no square after the top bit), then a read-out.
//   Worst case d=16, 63-bit exponent: 125 products.
//   The single multiply-accumulate pipeline takes one term per cycle,
//   fed by the two read ports of the matrix memory.
// Reset: order returns to 1, the unit goes idle, no result is pending.
// The memory holds three matrix slots; two pointers name accumulator and
// base, products go to the third slot and that matrix's pointer moves there.
// ----------------------------------------------------------------------------
module recurrence_matrix_power_mod_unit
  import rmp_pkg::*;
#(
  parameter int unsigned MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               order_we_i,
  input  logic [ORDER_W-1:0] order_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [EXP_W-1:0]   exponent_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [MOD_W-1:0]   value_o
);

  localparam int unsigned MM    = MAX_ORDER * MAX_ORDER;
  localparam int unsigned DEPTH = 3 * MM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_ORDER + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // Flat address of entry [row][col] of a slot
  function automatic logic [AW-1:0] addr_of(input logic [1:0] slot,
                                            input logic [CW-1:0] row,
                                            input logic [CW-1:0] col);
    addr_of = AW'(slot) * AW'(MM) + AW'(row) * AW'(MAX_ORDER) + AW'(col);
  endfunction

  logic [ORDER_W-1:0] order_q;
  logic [2:0]         state_q, state_d;
  logic [EXP_W-1:0]   ex_q, ex_d;
  logic [CW-1:0]      dim_q, dim_d, dim_in;
  logic [CW-1:0]      i_q, i_d, j_q, j_d, k_q, k_d;
  logic               phase_q, phase_d;   // init: 0 accumulator, 1 base
  logic               sq_q, sq_d;         // product kind: 1 squares the base
  logic [1:0]         pa_q, pa_d, pb_q, pb_d, pf;
  logic               out_v_q, out_v_d;
  logic [MOD_W-1:0]   out_q, out_d;

  logic               iss_v_q;
  mac_tag_t           iss_tag_q;
  logic [AW-1:0]      iss_waddr_q;

  logic [AW-1:0]      raddr_a, raddr_b, mem_waddr;
  logic [MOD_W-1:0]   rdata_a, rdata_b, mem_wdata;
  logic               mem_we;
  logic               mac_we, mac_busy;
  logic [AW-1:0]      mac_waddr;
  logic [MOD_W-1:0]   mac_wdata;
  logic               init_one, i_end, j_end, k_end;
  logic               issue;
  mac_tag_t           tag;

  // Effective dimension from the order register
  always_comb begin
    if (order_q == '0) begin
      dim_in = CW'(1);
    end else if (int'(order_q) > int'(MAX_ORDER)) begin
      dim_in = CW'(MAX_ORDER);
    end else begin
      dim_in = CW'(order_q);
    end
  end

  assign pf    = 2'd3 - pa_q - pb_q;
  assign i_end = (i_q == dim_q - CW'(1));
  assign j_end = (j_q == dim_q - CW'(1));
  assign k_end = (k_q == dim_q - CW'(1));
  assign issue = (state_q == S_MUL);
  assign tag.first = (k_q == '0);
  assign tag.last  = k_end;

  // Companion matrix: [0][0], [0][d-1] and the subdiagonal
  always_comb begin
    if (!phase_q) begin
      init_one = (i_q == j_q);
    end else begin
      init_one = ((i_q == '0) && ((j_q == '0) || j_end)) ||
                 ((i_q != '0) && (j_q == i_q - CW'(1)));
    end
  end

  always_comb begin
    raddr_a = addr_of(sq_q ? pb_q : pa_q, i_q, k_q);
    raddr_b = addr_of(pb_q, k_q, j_q);
    if (state_q == S_RD || state_q == S_OUT) begin
      raddr_a = addr_of(pa_q, '0, '0);
    end
    if (state_q == S_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = addr_of(phase_q ? pb_q : pa_q, i_q, j_q);
      mem_wdata = MOD_W'(init_one);
    end else begin
      mem_we    = mac_we;
      mem_waddr = mac_waddr;
      mem_wdata = mac_wdata;
    end
  end

  always_comb begin
    state_d = state_q;
    ex_d    = ex_q;
    dim_d   = dim_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    phase_d = phase_q;
    sq_d    = sq_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    out_v_d = out_v_q & out_stall_i;
    out_d   = out_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ex_d    = exponent_i;
          dim_d   = dim_in;
          i_d     = '0;
          j_d     = '0;
          phase_d = 1'b0;
          pa_d    = 2'd0;
          pb_d    = 2'd1;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        if (j_end) begin
          j_d = '0;
          if (i_end) begin
            i_d = '0;
            if (phase_q) begin
              state_d = S_CHK;
            end else begin
              phase_d = 1'b1;
            end
          end else begin
            i_d = i_q + CW'(1);
          end
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      S_CHK: begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
        if (ex_q == '0) begin
          state_d = S_RD;
        end else begin
          sq_d    = ~ex_q[0];
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (k_end) begin
          k_d = '0;
          if (j_end) begin
            j_d = '0;
            if (i_end) begin
              state_d = S_DRAIN;
            end else begin
              i_d = i_q + CW'(1);
            end
          end else begin
            j_d = j_q + CW'(1);
          end
        end else begin
          k_d = k_q + CW'(1);
        end
      end
      S_DRAIN: begin
        if (!iss_v_q && !mac_busy) begin
          if (sq_q) begin
            pb_d = pf;
            ex_d = ex_q >> 1;
          end else begin
            pa_d = pf;
            ex_d = {ex_q[EXP_W-1:1], 1'b0};
          end
          state_d = S_CHK;
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_v_q || !out_stall_i) begin
          out_v_d = 1'b1;
          out_d   = rdata_a;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_W'(1);
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      iss_v_q <= 1'b0;
      pa_q    <= 2'd0;
      pb_q    <= 2'd1;
    end else begin
      if (order_we_i) begin
        order_q <= order_i;
      end
      state_q <= state_d;
      out_v_q <= out_v_d;
      iss_v_q <= issue;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ex_q        <= ex_d;
    dim_q       <= dim_d;
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    phase_q     <= phase_d;
    sq_q        <= sq_d;
    out_q       <= out_d;
    iss_tag_q   <= tag;
    iss_waddr_q <= addr_of(pf, i_q, j_q);
  end

  rmp_mat_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  rmp_modmac #(
    .AW(AW)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (iss_v_q),
    .tag_i    (iss_tag_q),
    .waddr_i  (iss_waddr_q),
    .x_i      (rdata_a),
    .y_i      (rdata_b),
    .wr_en_o  (mac_we),
    .wr_addr_o(mac_waddr),
    .wr_data_o(mac_wdata),
    .busy_o   (mac_busy)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_v_q;
  assign value_o     = out_q;

`ifndef SYNTHESIS
  // Accumulator and base never share a slot
  a_ptr_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pa_q != pb_q && pa_q != 2'd3 && pb_q != 2'd3)
    else $error("matrix slot pointers collide");

  // No product terms in flight once the unit is idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!mac_busy && !iss_v_q))
    else $error("multiply pipeline busy while idle");

  // A result appears only out of the read-out step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> ($past(state_q) == S_OUT))
    else $error("result loaded outside read-out");
`endif

endmodule

@@ src/rmp_mat_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmp_mat_mem
// Matrix store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rmp_mat_mem
  import rmp_pkg::*;
#(
  parameter int unsigned DEPTH = 3 * DEF_MAX_ORDER * DEF_MAX_ORDER,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [MOD_W-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [MOD_W-1:0] rdata_a_o,
  output logic [MOD_W-1:0] rdata_b_o
);

  logic [MOD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

@@ src/rmp_modmac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmp_modmac
// Pipelined modular multiply-accumulate: product, Barrett reduction, sum.
// ----------------------------------------------------------------------------
module rmp_modmac
  import rmp_pkg::*;
#(
  parameter int unsigned AW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  mac_tag_t         tag_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [MOD_W-1:0] x_i,
  input  logic [MOD_W-1:0] y_i,
  output logic             wr_en_o,
  output logic [AW-1:0]    wr_addr_o,
  output logic [MOD_W-1:0] wr_data_o,
  output logic             busy_o
);

  localparam logic [31:0] MOD32  = 32'(MODULUS);
  localparam logic [31:0] MOD32X2 = MOD32 << 1;

  logic           v1_q, v2_q, v3_q, v4_q, wr_q;
  mac_tag_t       t1_q, t2_q, t3_q, t4_q;
  logic [AW-1:0]  a1_q, a2_q, a3_q, a4_q, wa_q;
  logic [59:0]    p1_q;
  logic [61:0]    h2_q;
  logic [31:0]    p2_q, p3_q, qm3_q;
  logic [MOD_W-1:0] r4_q, acc_q, wd_q;

  logic [31:0]      rem;
  logic [31:0]      rem_fix;
  logic [MOD_W:0]   sum;
  logic [MOD_W-1:0] res;

  always_comb begin
    rem = p3_q - qm3_q;
    if (rem >= MOD32X2) begin
      rem_fix = rem - MOD32X2;
    end else if (rem >= MOD32) begin
      rem_fix = rem - MOD32;
    end else begin
      rem_fix = rem;
    end
    sum = {1'b0, (t4_q.first ? '0 : acc_q)} + {1'b0, r4_q};
    if (sum >= {1'b0, MODULUS}) begin
      sum = sum - {1'b0, MODULUS};
    end
    res = sum[MOD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      wr_q <= v4_q & t4_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= tag_i;
    a1_q  <= waddr_i;
    p1_q  <= 60'(x_i) * 60'(y_i);
    t2_q  <= t1_q;
    a2_q  <= a1_q;
    p2_q  <= p1_q[31:0];
    h2_q  <= 62'(p1_q[59:29]) * 62'(MU);
    t3_q  <= t2_q;
    a3_q  <= a2_q;
    p3_q  <= p2_q;
    qm3_q <= 32'(h2_q[61:31]) * MOD32;
    t4_q  <= t3_q;
    a4_q  <= a3_q;
    r4_q  <= rem_fix[MOD_W-1:0];
    if (v4_q) begin
      acc_q <= res;
    end
    wd_q <= res;
    wa_q <= a4_q;
  end

  assign wr_en_o   = wr_q;
  assign wr_addr_o = wa_q;
  assign wr_data_o = wd_q;
  assign busy_o    = v1_q | v2_q | v3_q | v4_q | wr_q;

endmodule
